// ===== rtl/core/ffpa_pkg.sv =====
package ffpa_pkg;

  // Free list depth; every list width below follows from it.
  localparam int unsigned FREE_SLOTS = 64;
  localparam int unsigned SLOT_W     = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(FREE_SLOTS + 1);

  localparam int unsigned OFF_W   = 48;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned REQ_W   = 31;
  localparam int unsigned BLK_W   = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [BLK_W-1:0] BLK_SIZE_RST = BLK_W'(4096);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLK_SIZE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 1'b1;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [REQ_W-1:0]  request_size;
    logic [OFF_W-1:0]  free_offset;
    logic [SIZE_W-1:0] free_size;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  page_offset;
    logic [SIZE_W-1:0] page_size;
    logic              reused;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

// ===== rtl/core/first_fit_page_allocator.sv =====
// First-fit page allocator. Allocate requests are rounded up to a multiple of
// the block size by a bit-serial remainder unit, then the free list is scanned
// in insertion order through an entry memory, one entry a cycle; a hit is
// removed by sliding the later entries down one slot, again one a cycle. A
// free appends its entry to the end of the list unless it is full, and either
// command waits in its response state while the output register stays full.
// The input is taken only when the sequencer is idle, and the finished result
// sits in an output register so the next item can be accepted while it waits.
// Writing start_offset also reloads the end pointer.
module first_fit_page_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ffpa_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffpa_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ffpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FRESH = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  localparam int unsigned BITCNT_W = $clog2(REQ_W);

  logic [2:0]          state_q, state_d;
  logic [BLK_W-1:0]    blk_size_q;
  logic [OFF_W-1:0]    end_ptr_q, end_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [REQ_W-1:0]    div_sh_q, div_sh_d;
  logic [BLK_W-1:0]    rem_q, rem_d;
  logic [BITCNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [SIZE_W-1:0]   aligned_q, aligned_d;
  logic [CNT_W-1:0]    scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]    data_idx_q, data_idx_d;
  logic                data_vld_q, data_vld_d;
  logic [CNT_W-1:0]    wr_ptr_q, wr_ptr_d;
  out_item_t           res_q, res_d;
  out_item_t           out_q;
  logic                out_valid_q;

  entry_t              mem [FREE_SLOTS];
  entry_t              rd_q;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic [SLOT_W-1:0]   mem_raddr;

  logic [BLK_W-1:0]    bs_eff;
  logic [BLK_W:0]      trial;
  logic                hit;
  logic [OFF_W:0]      fresh_sum;
  logic                in_xfer;
  logic                out_load;
  logic [CNT_W-1:0]    wr_next;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Zero block size means no rounding.
  assign bs_eff    = (blk_size_q == '0) ? BLK_W'(1) : blk_size_q;
  assign trial     = {rem_q, div_sh_q[REQ_W-1]};
  assign hit       = data_vld_q && (rd_q.size >= aligned_q);
  assign fresh_sum = {1'b0, end_ptr_q} + (OFF_W+1)'(aligned_q);
  assign wr_next   = wr_ptr_q + CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    end_ptr_d  = end_ptr_q;
    count_d    = count_q;
    req_d      = req_q;
    div_sh_d   = div_sh_q;
    rem_d      = rem_q;
    bit_cnt_d  = bit_cnt_q;
    aligned_d  = aligned_q;
    scan_ptr_d = scan_ptr_q;
    data_idx_d = data_idx_q;
    data_vld_d = 1'b0;
    wr_ptr_d   = wr_ptr_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_d = '0;
          if (in_item_i.cmd == CMD_FREE) begin
            if (count_q == CNT_W'(FREE_SLOTS)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we           = 1'b1;
              mem_waddr        = count_q[SLOT_W-1:0];
              mem_wdata.offset = in_item_i.free_offset;
              mem_wdata.size   = in_item_i.free_size;
              count_d          = count_q + CNT_W'(1);
              res_d.status     = ST_OK;
            end
            state_d = S_RESP;
          end else begin
            req_d     = in_item_i.request_size;
            div_sh_d  = in_item_i.request_size;
            rem_d     = '0;
            bit_cnt_d = BITCNT_W'(REQ_W - 1);
            state_d   = S_DIV;
          end
        end
      end

      // Restoring remainder, one request bit a cycle, MSB first.
      S_DIV: begin
        if (trial >= {1'b0, bs_eff}) begin
          rem_d = BLK_W'(trial - {1'b0, bs_eff});
        end else begin
          rem_d = trial[BLK_W-1:0];
        end
        div_sh_d = {div_sh_q[REQ_W-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          state_d = S_ALIGN;
        end else begin
          bit_cnt_d = bit_cnt_q - BITCNT_W'(1);
        end
      end

      S_ALIGN: begin
        if (rem_q == '0) begin
          aligned_d = SIZE_W'(req_q);
        end else begin
          aligned_d = SIZE_W'(req_q) + SIZE_W'(bs_eff - rem_q);
        end
        scan_ptr_d = '0;
        state_d    = (count_q == '0) ? S_FRESH : S_SCAN;
      end

      // Issue one read a cycle; compare the entry read the cycle before.
      S_SCAN: begin
        mem_raddr  = scan_ptr_q[SLOT_W-1:0];
        scan_ptr_d = scan_ptr_q + CNT_W'(1);
        data_idx_d = scan_ptr_q;
        data_vld_d = (scan_ptr_q < count_q);
        if (hit) begin
          res_d.page_offset = rd_q.offset;
          res_d.page_size   = rd_q.size;
          res_d.reused      = 1'b1;
          res_d.status      = ST_OK;
          wr_ptr_d          = data_idx_q;
          data_vld_d        = 1'b0;
          state_d           = S_SHIFT;
        end else if (data_vld_q && (data_idx_q == count_q - CNT_W'(1))) begin
          data_vld_d = 1'b0;
          state_d    = S_FRESH;
        end
      end

      // Slide later entries down one slot; rd_q holds entry wr_ptr + 1.
      S_SHIFT: begin
        if (wr_next < count_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_ptr_q[SLOT_W-1:0];
          mem_wdata = rd_q;
          mem_raddr = SLOT_W'(wr_ptr_q + CNT_W'(2));
          wr_ptr_d  = wr_next;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_FRESH: begin
        if (fresh_sum[OFF_W]) begin
          res_d        = '0;
          res_d.status = ST_EXHAUSTED;
        end else begin
          res_d.page_offset = end_ptr_q;
          res_d.page_size   = aligned_q;
          res_d.reused      = 1'b0;
          res_d.status      = ST_OK;
          end_ptr_d         = fresh_sum[OFF_W-1:0];
        end
        state_d = S_RESP;
      end

      // Hold until the output register is free.
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blk_size_q  <= BLK_SIZE_RST;
      end_ptr_q   <= '0;
      count_q     <= '0;
      data_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      data_vld_q <= data_vld_d;
      if (cfg_we_i && (cfg_idx_i == REG_BLK_SIZE)) begin
        blk_size_q <= cfg_data_i[BLK_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_START_OFFSET)) begin
        end_ptr_q <= cfg_data_i[OFF_W-1:0];
      end else begin
        end_ptr_q <= end_ptr_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    div_sh_q   <= div_sh_d;
    rem_q      <= rem_d;
    bit_cnt_q  <= bit_cnt_d;
    aligned_q  <= aligned_d;
    scan_ptr_q <= scan_ptr_d;
    data_idx_q <= data_idx_d;
    wr_ptr_q   <= wr_ptr_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  a_count_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FREE_SLOTS)
  ) else $error("free list count beyond capacity");

  a_free_append: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_item_i.cmd == CMD_FREE) && (count_q != CNT_W'(FREE_SLOTS))
    |=> count_q == $past(count_q) + CNT_W'(1)
  ) else $error("free transfer did not append an entry");

  a_exhausted_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_EXHAUSTED)
    |-> !out_item_o.reused && (out_item_o.page_size == '0)
  ) else $error("exhausted result carries a page");

endmodule

// ===== tb/first_fit_page_allocator_tb.sv =====
module first_fit_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam logic [63:0] OFF_MAX     = (64'd1 << OFF_W) - 64'd1;

  typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} mix_e;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_item_t              item;
    logic                  known;
    out_item_t             want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // allocator state as the testbench sees it
  logic [BLK_W-1:0] blk_size = BLK_SIZE_RST;
  logic [OFF_W-1:0] end_ptr = '0;
  entry_t           free_list[$];

  out_item_t pages_due[$];
  dir_row_t  rows[$];
  int unsigned bad_fields = 0;
  int unsigned pages_seen = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;

  first_fit_page_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic out_item_t predict_page(in_item_t it);
    out_item_t   r;
    entry_t      e;
    logic [63:0] bs;
    logic [63:0] aligned;
    int          hit;
    r = '0;
    r.status = ST_OK;
    if (it.cmd == CMD_FREE) begin
      if (free_list.size() >= FREE_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        e.offset = it.free_offset;
        e.size = it.free_size;
        free_list = {free_list, e};
      end
      return r;
    end
    bs = (blk_size == '0) ? 64'd1 : 64'(blk_size);
    aligned = ((64'(it.request_size) + bs - 64'd1) / bs) * bs;
    hit = -1;
    for (int k = 0; k < free_list.size(); k++) begin
      if (hit < 0 && 64'(free_list[k].size) >= aligned) hit = k;
    end
    if (hit >= 0) begin
      r.page_offset = free_list[hit].offset;
      r.page_size = free_list[hit].size;
      r.reused = 1'b1;
      free_list.delete(hit);
      return r;
    end
    if (64'(end_ptr) + aligned > OFF_MAX) begin
      r.status = ST_EXHAUSTED;
      return r;
    end
    r.page_offset = end_ptr;
    r.page_size = aligned[SIZE_W-1:0];
    end_ptr = end_ptr + aligned[OFF_W-1:0];
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] rand_off();
    return OFF_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t rand_item(mix_e mix);
    in_item_t    it;
    int unsigned bs;
    int unsigned free_pct;
    bs = (blk_size == '0) ? 1 : int'(blk_size);
    case (mix)
      MIX_FILL: free_pct = 80;
      MIX_DRAIN: free_pct = 20;
      default: free_pct = 50;
    endcase
    it.cmd = ($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC;
    case ($urandom_range(0, 9))
      0: it.request_size = REQ_W'($urandom);
      1: it.request_size = '0;
      2: it.request_size = REQ_W'(bs * $urandom_range(0, 4));
      default: it.request_size = REQ_W'($urandom_range(0, 4 * bs));
    endcase
    it.free_offset = $urandom_range(0, 1) ? rand_off() : OFF_W'($urandom_range(0, 1 << 20));
    case ($urandom_range(0, 7))
      0: it.free_size = $urandom;
      1: it.free_size = '0;
      2: it.free_size = SIZE_W'(bs * $urandom_range(1, 4));
      default: it.free_size = SIZE_W'($urandom_range(0, 4 * bs));
    endcase
    return it;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    r.item = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t item_row(logic cmd, logic [REQ_W-1:0] req,
                                        logic [OFF_W-1:0] off, logic [SIZE_W-1:0] sz);
    dir_row_t r;
    r = cfg_row(REG_BLK_SIZE, '0);
    r.is_cfg = 1'b0;
    r.item.cmd = cmd;
    r.item.request_size = req;
    r.item.free_offset = off;
    r.item.free_size = sz;
    return r;
  endfunction

  function automatic dir_row_t known(dir_row_t r, logic [OFF_W-1:0] off,
                                     logic [SIZE_W-1:0] sz, logic reu, logic [STAT_W-1:0] st);
    r.known = 1'b1;
    r.want.page_offset = off;
    r.want.page_size = sz;
    r.want.reused = reu;
    r.want.status = st;
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    rows = {rows, r};
  endfunction

  task automatic flag_bad(string msg);
    bad_fields++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_page(out_item_t got);
    out_item_t want;
    if (pages_due.size() == 0) begin
      flag_bad($sformatf("result %0d arrived with nothing due", pages_seen));
      return;
    end
    want = pages_due.pop_front();
    if (got.page_offset !== want.page_offset)
      flag_bad($sformatf("result %0d page_offset %h, want %h", pages_seen,
                         got.page_offset, want.page_offset));
    if (got.page_size !== want.page_size)
      flag_bad($sformatf("result %0d page_size %h, want %h", pages_seen,
                         got.page_size, want.page_size));
    if (got.reused !== want.reused)
      flag_bad($sformatf("result %0d reused %b, want %b", pages_seen, got.reused, want.reused));
    if (got.status !== want.status)
      flag_bad($sformatf("result %0d status %0d, want %0d", pages_seen, got.status, want.status));
  endtask

  // Leaves valid high on return; the caller lowers it in the same step or sends again.
  task automatic push_item(in_item_t it, logic has_want, out_item_t typed_want);
    out_item_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
    predicted = predict_page(it);
    if (has_want) predicted = typed_want;
    pages_due = {pages_due, predicted};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pages_due.size() != 0) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_BLK_SIZE) begin
      blk_size = data[BLK_W-1:0];
    end else begin
      end_ptr = data[OFF_W-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic set_phase(int unsigned p);
    logic [CFG_DATA_W-1:0] blk;
    logic [CFG_DATA_W-1:0] start;
    logic [CFG_DATA_W-1:0] junk;
    bit                    load_start;
    load_start = 1'b1;
    start = '0;
    junk = '0;
    case (p)
      0: blk = CFG_DATA_W'(1);
      1: begin
        blk = CFG_DATA_W'(65536);
        load_start = 1'b0;
      end
      2: begin
        blk = '0;
        start = OFF_MAX[OFF_W-1:0] - OFF_W'($urandom_range(0, 64));
      end
      3: begin
        blk = CFG_DATA_W'(131071);
        start = rand_off();
      end
      4: begin
        blk = CFG_DATA_W'($urandom_range(1, 65536));
        load_start = 1'b0;
      end
      5: begin
        blk = CFG_DATA_W'($urandom_range(65537, 131071));
        start = OFF_MAX[OFF_W-1:0];
      end
      default: begin
        case ($urandom_range(0, 5))
          0: blk = '0;
          1: blk = CFG_DATA_W'(1);
          2: blk = CFG_DATA_W'(4096);
          3: blk = CFG_DATA_W'(65536);
          4: blk = CFG_DATA_W'(131071);
          default: blk = CFG_DATA_W'($urandom_range(0, 131071));
        endcase
        // junk above the register width must be dropped
        if ($urandom_range(0, 1) == 1) begin
          junk = CFG_DATA_W'(rand_off());
          blk = {junk[CFG_DATA_W-1:BLK_W], blk[BLK_W-1:0]};
        end
        case ($urandom_range(0, 2))
          0: load_start = 1'b0;
          1: start = rand_off();
          default: start = OFF_MAX[OFF_W-1:0] - OFF_W'($urandom_range(0, 1 << 24));
        endcase
      end
    endcase
    write_reg(REG_BLK_SIZE, blk);
    if (load_start) write_reg(REG_START_OFFSET, start);
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      check_page(out_item);
      pages_seen++;
    end
    if (stall_left != 0) begin
      out_ready <= (stall_left == 1);
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // after reset: block size 4096, end pointer 0, empty list
    add_row(known(item_row(CMD_ALLOC, 31'd0, '0, '0), 48'd0, 32'd0, 1'b0, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd1, '0, '0), 48'd0, 32'd4096, 1'b0, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd4096, '0, '0), 48'd4096, 32'd4096, 1'b0,
                  ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd4097, '0, '0), 48'd8192, 32'd8192, 1'b0,
                  ST_OK));
    add_row(known(item_row(CMD_FREE, '1, 48'h100, 32'd5000), '0, '0, 1'b0, ST_OK));
    add_row(known(item_row(CMD_FREE, '0, '1, '1), '0, '0, 1'b0, ST_OK));
    add_row(known(item_row(CMD_FREE, '0, '0, '0), '0, '0, 1'b0, ST_OK));
    // zero request takes the first entry
    add_row(known(item_row(CMD_ALLOC, 31'd0, '1, '1), 48'h100, 32'd5000, 1'b1, ST_OK));
    add_row(known(item_row(CMD_ALLOC, '1, '0, '0), '1, '1, 1'b1, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd1, '0, '0), 48'd16384, 32'd4096, 1'b0,
                  ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd0, '0, '0), 48'd0, 32'd0, 1'b1, ST_OK));
    // region exhausted at the top of the offset range
    add_row(cfg_row(REG_START_OFFSET, 48'hFFFF_FFFF_F000));
    add_row(known(item_row(CMD_ALLOC, 31'd4096, '0, '0), '0, '0, 1'b0, ST_EXHAUSTED));
    add_row(known(item_row(CMD_ALLOC, '1, '0, '0), '0, '0, 1'b0, ST_EXHAUSTED));
    add_row(cfg_row(REG_BLK_SIZE, 48'd0));
    add_row(known(item_row(CMD_ALLOC, 31'hFFF, '0, '0), 48'hFFFF_FFFF_F000, 32'hFFF,
                  1'b0, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd1, '0, '0), '0, '0, 1'b0, ST_EXHAUSTED));
    add_row(known(item_row(CMD_ALLOC, 31'd0, '0, '0), '1, '0, 1'b0, ST_OK));
    // block size above the nominal range
    add_row(cfg_row(REG_BLK_SIZE, 48'h1FFFF));
    add_row(cfg_row(REG_START_OFFSET, 48'd0));
    add_row(known(item_row(CMD_ALLOC, 31'd1, '0, '0), 48'd0, 32'd131071, 1'b0, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd131072, '0, '0), 48'd131071, 32'd262142,
                  1'b0, ST_OK));
    add_row(cfg_row(REG_BLK_SIZE, 48'hABCD_EF01_0000));
    add_row(known(item_row(CMD_FREE, '0, 48'h5555_5555_5555, 32'hAAAA_AAAA), '0, '0,
                  1'b0, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd65537, '0, '0), 48'h5555_5555_5555,
                  32'hAAAA_AAAA, 1'b1, ST_OK));
    add_row(known(item_row(CMD_ALLOC, 31'd65536, '0, '0), 48'd393213, 32'd65536, 1'b0,
                  ST_OK));
    add_row(cfg_row(REG_BLK_SIZE, 48'd1));
    add_row(item_row(CMD_FREE, 31'h2AAA_AAAA, 48'hAAAA_AAAA_AAAA, 32'h5555_5555));
    add_row(item_row(CMD_ALLOC, '1, '0, '0));
    add_row(item_row(CMD_ALLOC, 31'd1, '0, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        push_item(rows[i].item, rows[i].known, rows[i].want);
      end
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      set_phase(p);
      idle_en = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        push_item(rand_item(mix_e'(p % 3)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pages_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
